FILE: rtl/ccp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_pkg: shared types and constants of the credit task picker
// Table size, field widths, command and state codes, controller/datapath
// command and status bundles, and the priority clamp.
// ----------------------------------------------------------------------------
package ccp_pkg;

    localparam int NUM_TASKS = 64;
    localparam int TI_W      = $clog2(NUM_TASKS);
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);

    localparam int TASK_W    = 6;
    localparam int PRIO_W    = 6;
    localparam int CREDIT_W  = 7;

    localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
    localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(35);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_WAKE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_SCHED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WAKE,
        ST_TICK,
        ST_SCAN,
        ST_CHOOSE,
        ST_RELOAD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;         // latch the accepted item
        logic wr_entry;     // load one table entry
        logic wake_set;     // update runnable flag, issue credit reads
        logic wake_cmp;     // compare woken credit with the running one
        logic tick_wr;      // write back the running task's credit
        logic scan_init;
        logic scan_step;
        logic reload_init;
        logic reload_step;
        logic finish;       // commit and load the output register
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic cnt_end;
        logic reload_need;
        logic out_free;
    } t_dp_sts;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] r;
        r = p;
        if (p < PRIO_MIN) begin
            r = PRIO_MIN;
        end else if (p > PRIO_MAX) begin
            r = PRIO_MAX;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ccp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_ctrl: command sequencer
// Walks each item through decode, memory access, the scan and reload passes
// and the final commit.
// ----------------------------------------------------------------------------
module ccp_ctrl
    import ccp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_ctl      o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_WRITE: n_state = ST_FINISH;
                    CMD_WAKE:  n_state = ST_WAKE;
                    CMD_TICK:  n_state = ST_TICK;
                    CMD_SCHED: n_state = ST_SCAN;
                    default:   n_state = ST_FINISH;
                endcase
            end
            ST_WAKE:   n_state = ST_FINISH;
            ST_TICK:   n_state = ST_FINISH;
            ST_SCAN: begin
                if (i_sts.cnt_end) n_state = ST_CHOOSE;
            end
            ST_CHOOSE: n_state = i_sts.reload_need ? ST_RELOAD : ST_FINISH;
            ST_RELOAD: begin
                if (i_sts.cnt_end) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready  = 1'b1;
                o_ctl.load = i_valid;
            end
            ST_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_WRITE: o_ctl.wr_entry  = 1'b1;
                    CMD_WAKE:  o_ctl.wake_set  = 1'b1;
                    CMD_SCHED: o_ctl.scan_init = 1'b1;
                    default:   o_ctl = '0;   // tick: credit read only
                endcase
            end
            ST_WAKE:   o_ctl.wake_cmp  = 1'b1;
            ST_TICK:   o_ctl.tick_wr   = 1'b1;
            ST_SCAN:   o_ctl.scan_step = 1'b1;
            ST_CHOOSE: o_ctl.reload_init = i_sts.reload_need;
            ST_RELOAD: o_ctl.reload_step = 1'b1;
            ST_FINISH: o_ctl.finish    = i_sts.out_free;
            default:   o_ctl = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/ccp_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccp_dpath: task table and scheduling datapath
// Flag vectors, credit and priority memories, scan counter, best-candidate
// tracking and the output register.
// ----------------------------------------------------------------------------
module ccp_dpath
    import ccp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_ctl             i_ctl,
    output t_dp_sts                  o_sts,
    input  wire logic [1:0]          i_command,
    input  wire logic [TASK_W-1:0]   i_task_index,
    input  wire logic                i_present,
    input  wire logic                i_runnable,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    input  wire logic [CREDIT_W-1:0] i_initial_credit,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [TASK_W-1:0]        o_current_task,
    output logic                     o_need_resched,
    output logic                     o_switched,
    output logic                     o_credits_reloaded
);

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_TASKS);

    // latched item
    t_cmd                r_cmd;
    logic [TASK_W-1:0]   r_idx;
    logic                r_pres;
    logic                r_run;
    logic [PRIO_W-1:0]   r_prio;
    logic [CREDIT_W-1:0] r_credit;

    // table
    logic [NUM_TASKS-1:0] r_present;
    logic [NUM_TASKS-1:0] r_runnable;
    logic [CREDIT_W-1:0]  credit_mem [NUM_TASKS];
    logic [PRIO_W-1:0]    prio_mem   [NUM_TASKS];
    logic [CREDIT_W-1:0]  r_rd_a;
    logic [CREDIT_W-1:0]  r_rd_b;
    logic [PRIO_W-1:0]    r_rd_prio;

    logic [TI_W-1:0]      r_running;
    logic                 r_resched;
    logic                 r_wake_hit;

    // scan state
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pv;
    logic [TI_W-1:0]      r_pidx;
    logic                 r_found;
    logic [CREDIT_W-1:0]  r_best;
    logic [TI_W-1:0]      r_best_idx;
    logic                 r_reloaded;

    logic                 r_out_valid;

    logic                 in_table;
    logic [TI_W-1:0]      tidx;
    logic                 cnt_end;
    logic                 stepping;
    logic [TI_W-1:0]      addr_a;
    logic                 wr_en;
    logic [TI_W-1:0]      wr_addr;
    logic [CREDIT_W-1:0]  wr_data;
    logic                 tick_zero;
    logic                 cand;
    logic [CREDIT_W-1:0]  reload_val;

    assign in_table = (int'(r_idx) < NUM_TASKS);
    assign tidx     = TI_W'(r_idx);
    assign cnt_end  = (r_cnt == CNT_END);
    assign stepping = i_ctl.scan_step || i_ctl.reload_step;

    always_comb begin
        if (stepping) begin
            addr_a = r_cnt[TI_W-1:0];
        end else if (r_cmd == CMD_WAKE) begin
            addr_a = tidx;
        end else begin
            addr_a = r_running;
        end
    end

    assign tick_zero  = (r_running == '0) || (r_rd_a <= CREDIT_W'(1));
    assign cand       = r_pv && r_present[r_pidx] && r_runnable[r_pidx]
                        && (!r_found || (r_rd_a > r_best));
    assign reload_val = {1'b0, r_rd_a[CREDIT_W-1:1]} + CREDIT_W'(r_rd_prio);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_running;
        wr_data = '0;
        if (i_ctl.wr_entry) begin
            wr_en   = in_table;
            wr_addr = tidx;
            wr_data = r_credit;
        end else if (i_ctl.tick_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_running;
            wr_data = tick_zero ? '0 : r_rd_a - CREDIT_W'(1);
        end else if (i_ctl.reload_step) begin
            wr_en   = r_pv && r_present[r_pidx];
            wr_addr = r_pidx;
            wr_data = reload_val;
        end
    end

    // credit memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) credit_mem[wr_addr] <= wr_data;
        r_rd_a <= credit_mem[addr_a];
        r_rd_b <= credit_mem[r_running];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_entry && in_table) prio_mem[tidx] <= clamp_prio(r_prio);
        r_rd_prio <= prio_mem[addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_idx    <= i_task_index;
            r_pres   <= i_present;
            r_run    <= i_runnable;
            r_prio   <= i_priority_req;
            r_credit <= i_initial_credit;
        end
        if (i_ctl.wake_set) begin
            r_wake_hit <= in_table && r_present[tidx] && r_run && !r_runnable[tidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_WRITE;
            r_present   <= '0;
            r_runnable  <= '0;
            r_running   <= '0;
            r_resched   <= 1'b0;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_pidx      <= '0;
            r_found     <= 1'b0;
            r_best      <= '0;
            r_best_idx  <= '0;
            r_reloaded  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.load) r_cmd <= t_cmd'(i_command);

            if (i_ctl.wr_entry && in_table) begin
                r_present[tidx]  <= r_pres;
                r_runnable[tidx] <= r_run;
            end

            if (i_ctl.wake_set && in_table && r_present[tidx]) begin
                r_runnable[tidx] <= r_run;
            end

            if (i_ctl.wake_cmp && r_wake_hit && (r_rd_a > r_rd_b)) r_resched <= 1'b1;
            if (i_ctl.tick_wr && tick_zero) r_resched <= 1'b1;

            if (i_ctl.scan_init || i_ctl.reload_init) begin
                r_cnt <= CNT_W'(1);
                r_pv  <= 1'b0;
            end else if (stepping) begin
                r_pv   <= !cnt_end;
                r_pidx <= r_cnt[TI_W-1:0];
                if (!cnt_end) r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_ctl.scan_init) begin
                r_resched  <= 1'b0;
                r_found    <= 1'b0;
                r_best     <= '0;
                r_best_idx <= '0;
                r_reloaded <= 1'b0;
            end else if (i_ctl.scan_step && cand) begin
                r_found    <= 1'b1;
                r_best     <= r_rd_a;
                r_best_idx <= r_pidx;
            end

            if (i_ctl.reload_init) r_reloaded <= 1'b1;

            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
                if (r_cmd == CMD_SCHED) r_running <= r_best_idx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            o_need_resched <= r_resched;
            if (r_cmd == CMD_SCHED) begin
                o_current_task     <= TASK_W'(r_best_idx);
                o_switched         <= (r_best_idx != r_running);
                o_credits_reloaded <= r_reloaded;
            end else begin
                o_current_task     <= TASK_W'(r_running);
                o_switched         <= 1'b0;
                o_credits_reloaded <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sts.cmd         = r_cmd;
    assign o_sts.cnt_end     = cnt_end;
    assign o_sts.reload_need = r_found && (r_best == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

FILE: rtl/counter_credit_task_picker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// counter_credit_task_picker_top: credit based task picker
// Takes one command item at a time and returns one result item for each.
// ----------------------------------------------------------------------------
// One command is in flight at a time; the input is ready again as soon as the
// sequencer is back in idle, even while the last result waits to be taken.
// Wake and tick make one registered read of the credit memory, then compare
// or write back. A schedule runs a scan pass and, when all credits are
// reloaded, a reload pass; its length is set by the credit memory read port,
// which visits entries 1 .. NUM_TASKS-1 one per cycle in the scan and again
// in the reload pass.
// Entries never written read back as undefined credit and priority.
module counter_credit_task_picker_top
    import ccp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [TASK_W-1:0]   i_task_index,
    input  wire logic                i_present,
    input  wire logic                i_runnable,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    input  wire logic [CREDIT_W-1:0] i_initial_credit,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [TASK_W-1:0]        o_current_task,
    output logic                     o_need_resched,
    output logic                     o_switched,
    output logic                     o_credits_reloaded
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    ccp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    ccp_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_command          (i_command),
        .i_task_index       (i_task_index),
        .i_present          (i_present),
        .i_runnable         (i_runnable),
        .i_priority_req     (i_priority_req),
        .i_initial_credit   (i_initial_credit),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_current_task     (o_current_task),
        .o_need_resched     (o_need_resched),
        .o_switched         (o_switched),
        .o_credits_reloaded (o_credits_reloaded)
    );

endmodule
`default_nettype wire

FILE: tb/sv/picker_checker.sv
// ----------------------------------------------------------------------------
// picker_checker: result predictor and scoreboard for the credit task picker
// Watches both item channels. Every accepted command runs through a local
// copy of the task table, and the outcome it predicts is queued. Each
// accepted result is checked against the oldest queued outcome.
// ----------------------------------------------------------------------------
module picker_checker
    import ccp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [TASK_W-1:0]   i_task_index,
    input  wire logic                i_present,
    input  wire logic                i_runnable,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    input  wire logic [CREDIT_W-1:0] i_initial_credit,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [TASK_W-1:0]   i_current_task,
    input  wire logic                i_need_resched,
    input  wire logic                i_switched,
    input  wire logic                i_credits_reloaded,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TASK_W-1:0] cur_task;
        logic              resched;
        logic              switched;
        logic              reloaded;
    } t_outcome;

    // local copy of the task table
    logic                tbl_present  [NUM_TASKS];
    logic                tbl_runnable [NUM_TASKS];
    logic [PRIO_W-1:0]   tbl_prio     [NUM_TASKS];
    logic [CREDIT_W-1:0] tbl_credit   [NUM_TASKS];
    logic [TASK_W-1:0]   run_task;
    logic                resched_pend;

    t_outcome sched_outcomes[$];
    int       mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic apply_command(
        input  t_cmd                cmd,
        input  logic [TASK_W-1:0]   idx,
        input  logic                pres,
        input  logic                run,
        input  logic [PRIO_W-1:0]   prio,
        input  logic [CREDIT_W-1:0] credit,
        output t_outcome            res
    );
        logic [PRIO_W-1:0]   prio_c;
        logic [TASK_W-1:0]   best_idx;
        logic [CREDIT_W-1:0] best_credit;
        logic                found;
        bit                  in_table;

        res      = '0;
        in_table = int'(idx) < NUM_TASKS;
        case (cmd)
            CMD_WRITE: begin
                prio_c = prio;
                if (prio < PRIO_MIN) begin
                    prio_c = PRIO_MIN;
                end else if (prio > PRIO_MAX) begin
                    prio_c = PRIO_MAX;
                end
                if (in_table) begin
                    tbl_present[idx]  = pres;
                    tbl_runnable[idx] = run;
                    tbl_prio[idx]     = prio_c;
                    tbl_credit[idx]   = credit;
                end
            end
            CMD_WAKE: begin
                if (in_table && tbl_present[idx]) begin
                    if (!run) begin
                        tbl_runnable[idx] = 1'b0;
                    end else if (!tbl_runnable[idx]) begin
                        tbl_runnable[idx] = 1'b1;
                        if (tbl_credit[idx] > tbl_credit[run_task]) begin
                            resched_pend = 1'b1;
                        end
                    end
                end
            end
            CMD_TICK: begin
                // the idle task never holds credit
                if (run_task == '0 || tbl_credit[run_task] <= 1) begin
                    tbl_credit[run_task] = '0;
                    resched_pend         = 1'b1;
                end else begin
                    tbl_credit[run_task] = tbl_credit[run_task] - 1'b1;
                end
            end
            default: begin
                resched_pend = 1'b0;
                found        = 1'b0;
                best_idx     = '0;
                best_credit  = '0;
                // strict compare: first entry wins a tie
                for (int i = 1; i < NUM_TASKS; i++) begin
                    if (tbl_present[i] && tbl_runnable[i] &&
                        (!found || tbl_credit[i] > best_credit)) begin
                        found       = 1'b1;
                        best_credit = tbl_credit[i];
                        best_idx    = TASK_W'(i);
                    end
                end
                if (found && best_credit == '0) begin
                    res.reloaded = 1'b1;
                    for (int i = 1; i < NUM_TASKS; i++) begin
                        if (tbl_present[i]) begin
                            tbl_credit[i] = (tbl_credit[i] >> 1) + CREDIT_W'(tbl_prio[i]);
                        end
                    end
                end
                res.switched = best_idx != run_task;
                run_task     = best_idx;
            end
        endcase
        res.cur_task = run_task;
        res.resched  = resched_pend;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;

        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                tbl_present[i]  = 1'b0;
                tbl_runnable[i] = 1'b0;
                tbl_prio[i]     = '0;
                tbl_credit[i]   = '0;
            end
            run_task     = '0;
            resched_pend = 1'b0;
            sched_outcomes.delete();
        end else begin
            // check first: a result never leaves on the edge its command enters
            if (i_out_valid && i_out_ready) begin
                got = '{i_current_task, i_need_resched, i_switched, i_credits_reloaded};
                if (sched_outcomes.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: result with none pending: task %0d resched %0b sw %0b rl %0b",
                                 $realtime, got.cur_task, got.resched, got.switched,
                                 got.reloaded);
                    end
                    mismatches++;
                end else begin
                    want = sched_outcomes.pop_front();
                    if (got !== want) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: mismatch task exp %0d got %0d, resched exp %0b got %0b, switched exp %0b got %0b, reloaded exp %0b got %0b",
                                     $realtime, want.cur_task, got.cur_task,
                                     want.resched, got.resched, want.switched,
                                     got.switched, want.reloaded, got.reloaded);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_command(t_cmd'(i_command), i_task_index, i_present, i_runnable,
                              i_priority_req, i_initial_credit, want);
                sched_outcomes.push_back(want);
            end
        end
        o_pending    <= sched_outcomes.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the credit task picker
// Fills the task table, runs a directed command sequence, then random
// commands over four handshake phases: no idling, sender gaps, receiver
// stalls, and light idling on both sides. Checking is done by picker_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import ccp_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 2 * NUM_TASKS + 20;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_ready;
    logic [1:0]          i_command        = CMD_WRITE;
    logic [TASK_W-1:0]   i_task_index     = '0;
    logic                i_present        = 1'b0;
    logic                i_runnable       = 1'b0;
    logic [PRIO_W-1:0]   i_priority_req   = '0;
    logic [CREDIT_W-1:0] i_initial_credit = '0;
    logic                o_valid;
    logic                i_ready          = 1'b0;
    logic [TASK_W-1:0]   o_current_task;
    logic                o_need_resched;
    logic                o_switched;
    logic                o_credits_reloaded;

    int fail_count;
    int pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    counter_credit_task_picker_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_command          (i_command),
        .i_task_index       (i_task_index),
        .i_present          (i_present),
        .i_runnable         (i_runnable),
        .i_priority_req     (i_priority_req),
        .i_initial_credit   (i_initial_credit),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_current_task     (o_current_task),
        .o_need_resched     (o_need_resched),
        .o_switched         (o_switched),
        .o_credits_reloaded (o_credits_reloaded)
    );

    picker_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_command          (i_command),
        .i_task_index       (i_task_index),
        .i_present          (i_present),
        .i_runnable         (i_runnable),
        .i_priority_req     (i_priority_req),
        .i_initial_credit   (i_initial_credit),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_current_task     (o_current_task),
        .i_need_resched     (o_need_resched),
        .i_switched         (o_switched),
        .i_credits_reloaded (o_credits_reloaded),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= $urandom_range(99) >= receiver_stall_pct;
    end

    // ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_command(
        input t_cmd                cmd,
        input logic [TASK_W-1:0]   idx,
        input logic                pres,
        input logic                run,
        input logic [PRIO_W-1:0]   prio,
        input logic [CREDIT_W-1:0] credit
    );
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_task_index     <= idx;
        i_present        <= pres;
        i_runnable       <= run;
        i_priority_req   <= prio;
        i_initial_credit <= credit;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_command;
        int                  sel;
        t_cmd                cmd;
        logic [TASK_W-1:0]   idx;
        logic                pres;
        logic [CREDIT_W-1:0] credit;

        sel = $urandom_range(99);
        if (sel < 20) begin
            cmd = CMD_WRITE;
        end else if (sel < 50) begin
            cmd = CMD_WAKE;
        end else if (sel < 80) begin
            cmd = CMD_TICK;
        end else begin
            cmd = CMD_SCHED;
        end
        // a small pool of tasks keeps wakes, ticks and picks interacting
        if ($urandom_range(9) < 7) begin
            idx = TASK_W'($urandom_range(15));
        end else begin
            idx = TASK_W'($urandom);
        end
        pres = (cmd == CMD_WRITE) ? ($urandom_range(99) < 85) : 1'($urandom);
        // low credits run out quickly and force reloads
        if ($urandom_range(99) < 60) begin
            credit = CREDIT_W'($urandom_range(7));
        end else begin
            credit = CREDIT_W'($urandom);
        end
        send_command(cmd, idx, pres, $urandom_range(99) < 65, PRIO_W'($urandom), credit);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every entry written once, absent, so no scan reads an unset credit
        for (int n = 0; n < NUM_TASKS; n++) begin
            send_command(CMD_WRITE, TASK_W'(n), 1'b0, 1'($urandom), PRIO_W'($urandom),
                         CREDIT_W'($urandom));
        end

        send_command(CMD_WRITE, 6'd0, 1'b1, 1'b1, 6'd0, 7'd0);     // priority 0 -> 1
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);           // nothing runnable
        send_command(CMD_TICK, '0, 1'b0, 1'b0, '0, '0);            // idle task tick
        send_command(CMD_WRITE, 6'd1, 1'b1, 1'b1, 6'd63, 7'd0);    // priority clamped high
        send_command(CMD_WRITE, 6'd2, 1'b1, 1'b0, 6'd36, 7'd127);
        send_command(CMD_WRITE, 6'd3, 1'b1, 1'b1, 6'd1, 7'd0);
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);           // best is 0: reload
        send_command(CMD_WAKE, 6'd2, 1'b0, 1'b1, '0, '0);          // beats running task
        send_command(CMD_WAKE, 6'd2, 1'b1, 1'b1, '0, '0);          // already runnable
        send_command(CMD_WAKE, 6'd4, 1'b0, 1'b1, '0, '0);          // absent entry
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);
        send_command(CMD_TICK, '0, 1'b0, 1'b0, '0, '0);
        send_command(CMD_WAKE, 6'd2, 1'b0, 1'b0, '0, '0);          // sleep the running task
        send_command(CMD_TICK, '0, 1'b0, 1'b0, '0, '0);
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);
        send_command(CMD_WRITE, 6'd1, 1'b1, 1'b1, 6'd5, 7'd1);     // rewrite running task
        send_command(CMD_TICK, '0, 1'b0, 1'b0, '0, '0);            // credit runs out
        send_command(CMD_TICK, '0, 1'b0, 1'b0, '0, '0);            // tick at zero
        send_command(CMD_WRITE, 6'd63, 1'b1, 1'b0, 6'd20, 7'd127);
        send_command(CMD_WAKE, 6'd63, 1'b1, 1'b1, '0, '0);
        send_command(CMD_WRITE, 6'd62, 1'b1, 1'b1, 6'd20, 7'd127);
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);           // tie: lower index wins
        send_command(CMD_SCHED, '0, 1'b0, 1'b0, '0, '0);           // same pick again

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case (k * 4 / RANDOM_ITEMS)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 0;
                end
                1: begin
                    sender_idle_pct    = 62;
                    receiver_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct <= 62;
                end
                default: begin
                    sender_idle_pct    = 20;
                    receiver_stall_pct <= 20;
                end
            endcase
            send_random_command();
        end
        i_valid <= 1'b0;

        // let the checker count the last item before polling
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: counter_credit_task_picker_top.f
rtl/ccp_pkg.sv
rtl/ccp_ctrl.sv
rtl/ccp_dpath.sv
rtl/counter_credit_task_picker_top.sv
tb/sv/picker_checker.sv
tb/sv/tb_top.sv
